// ===== rtl/refcounted_id_allocator_defines.svh =====
// Assertion macros for the refcounted ID allocator.
// Expects clk and rst_n in the scope of each use.
`ifndef REFCOUNTED_ID_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_ID_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define RCA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcidalloc assertion failed");

// Next-cycle implication.
`define RCA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcidalloc assertion failed");

`endif

// ===== rtl/rcidalloc_pkg.sv =====
// Shared types and constants for the refcounted ID allocator.
// No dependencies.
package rcidalloc_pkg;

  localparam int ID_BITS        = 13;
  localparam int COUNT_BITS     = 32;
  localparam int REL_BITS       = 32;
  localparam int OUT_CNT_BITS   = 32;
  localparam int WORD_BITS      = 64;
  localparam int BIT_IDX_BITS   = 6;
  localparam int NUM_IDS        = 1 << ID_BITS;
  localparam int MAP_WORDS      = NUM_IDS / WORD_BITS;
  localparam int WORD_IDX_BITS  = ID_BITS - BIT_IDX_BITS;
  localparam int SCAN_BITS      = WORD_IDX_BITS + 1;
  localparam int CNT_EXT_BITS   = (COUNT_BITS > OUT_CNT_BITS) ? COUNT_BITS : OUT_CNT_BITS;
  localparam int FIRST_FREE_ID  = 2;
  localparam logic [WORD_BITS-1:0] RESERVED_WORD = WORD_BITS'(3);

  typedef enum logic [2:0] {
    OP_ALLOC  = 3'd0,
    OP_REF    = 3'd1,
    OP_FORGET = 3'd2,
    OP_QUERY  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } fsm_t;

  typedef struct packed {
    logic [2:0]          op;
    logic [ID_BITS-1:0]  target_id;
    logic [REL_BITS-1:0] release_count;
  } in_item_t;

  typedef struct packed {
    logic [ID_BITS-1:0]      result_id;
    logic [1:0]              status;
    logic                    is_active;
    logic [OUT_CNT_BITS-1:0] ref_count;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic exec_fire;
    logic scan_step;
    logic scan_fire;
  } dp_cmd_t;

  typedef struct packed {
    logic in_is_alloc;
    logic found;
    logic scan_last;
    logic slot_free;
  } dp_sts_t;

endpackage

// ===== rtl/refcounted_id_allocator.sv =====
// Top level of the refcounted ID allocator: sequencer plus datapath.
// Depends on rcidalloc_pkg, rcidalloc_ctrl, rcidalloc_dp, refcounted_id_allocator_defines.svh.
//
//   channel | ports                        | payload
//   input   | in_valid / in_ready          | in_item_t  (op, target_id, release_count)
//   result  | out_valid / out_ready        | out_item_t (result_id, status, is_active, ref_count)
//
// Reference, forget, query, clear and unknown ops do a RAM read, then an update.
// Allocate scans the bitmap words from the next-fit start; the single bitmap read port
// yields one 64-bit word per cycle.
// Reset and clear need no sweep: one valid flop per bitmap row restores reset contents.
// A finished result waits in the output register while the next item is taken; the
// sequencer stalls in its final state only when that register is still occupied.
`include "refcounted_id_allocator_defines.svh"
module refcounted_id_allocator import rcidalloc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  rcidalloc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rcidalloc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `RCA_ASSERT_NXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)
  `RCA_ASSERT_IMP(a_full_gives_zero, out_valid && out_data.status == ST_FULL,
                  out_data.result_id == '0 && !out_data.is_active)
  `RCA_ASSERT_IMP(a_ignored_clean, out_valid && out_data.status == ST_IGNORED,
                  out_data.ref_count == '0 && !out_data.is_active)
  `RCA_ASSERT_IMP(a_new_id_not_reserved, out_valid && out_data.result_id != '0,
                  out_data.result_id >= ID_BITS'(FIRST_FREE_ID) && out_data.is_active)

endmodule

// ===== rtl/rcidalloc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rcidalloc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/rcidalloc_ctrl.sv =====
// Sequencer for the refcounted ID allocator: idle, execute, bitmap scan.
// Depends on rcidalloc_pkg.
module rcidalloc_ctrl import rcidalloc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.in_is_alloc ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if ((sts.found || sts.scan_last) && sts.slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_EXEC: begin
        cmd.exec_fire = sts.slot_free;
      end
      S_SCAN: begin
        cmd.scan_fire = (sts.found || sts.scan_last) && sts.slot_free;
        cmd.scan_step = !sts.found && !sts.scan_last;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/rcidalloc_dp.sv =====
// Datapath: bitmap and count RAMs, row valid bits, next-fit scan, result register.
// Depends on rcidalloc_pkg and rcidalloc_ram.
module rcidalloc_dp import rcidalloc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  function automatic logic [BIT_IDX_BITS-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS-1:0]    iso;
    logic [BIT_IDX_BITS-1:0] pos;
    iso = v & (~v + WORD_BITS'(1));
    pos = '0;
    for (int b = 0; b < BIT_IDX_BITS; b++) begin
      for (int k = 0; k < WORD_BITS; k++) begin
        if (((k >> b) & 1) == 1) begin
          pos[b] = pos[b] | iso[k];
        end
      end
    end
    return pos;
  endfunction

  function automatic logic [OUT_CNT_BITS-1:0] sat_out(input logic [COUNT_BITS-1:0] c);
    logic [CNT_EXT_BITS-1:0] e;
    e = CNT_EXT_BITS'(c);
    if (e > CNT_EXT_BITS'({OUT_CNT_BITS{1'b1}})) begin
      return '1;
    end
    return e[OUT_CNT_BITS-1:0];
  endfunction

  logic [2:0]               op_r;
  logic [ID_BITS-1:0]       id_r;
  logic [REL_BITS-1:0]      rel_r;
  logic [ID_BITS-1:0]       last_r;
  logic [SCAN_BITS-1:0]     scan_i_r;
  logic [WORD_IDX_BITS-1:0] scan_idx_r;
  logic [BIT_IDX_BITS-1:0]  start_bit_r;
  logic [MAP_WORDS-1:0]     row_vld_r;
  logic                     map_vld_q;
  logic                     map_row0_q;
  logic                     out_valid_r;
  out_item_t                out_r, out_nxt;

  logic [ID_BITS:0]         start_sum;
  logic [ID_BITS-1:0]       start_id;
  logic                     map_rd_en;
  logic [WORD_IDX_BITS-1:0] map_rd_addr;
  logic [WORD_BITS-1:0]     map_rdata;
  logic                     map_wr_en;
  logic [WORD_IDX_BITS-1:0] map_wr_addr;
  logic [WORD_BITS-1:0]     map_wr_data;
  logic [COUNT_BITS-1:0]    cnt_rdata;
  logic                     cnt_wr_en;
  logic [ID_BITS-1:0]       cnt_wr_addr;
  logic [COUNT_BITS-1:0]    cnt_wr_data;

  logic [WORD_BITS-1:0]     eff_word;
  logic [WORD_BITS-1:0]     scan_word;
  logic [BIT_IDX_BITS-1:0]  free_pos;
  logic [ID_BITS-1:0]       new_id;
  logic                     found;
  logic                     tgt_active;
  logic                     tgt_reserved;
  logic [CNT_EXT_BITS-1:0]  cnt_ext, rel_ext, dec_ext;
  logic [COUNT_BITS-1:0]    cnt_inc, cnt_dec;
  logic                     do_clear;

  // next-fit start: last + 1, wrapped to the first free ID
  assign start_sum = {1'b0, last_r} + (ID_BITS + 1)'(1);
  assign start_id  = (start_sum[ID_BITS] || start_sum < (ID_BITS + 1)'(FIRST_FREE_ID)) ?
                     ID_BITS'(FIRST_FREE_ID) : start_sum[ID_BITS-1:0];

  assign map_rd_en   = cmd.accept || cmd.scan_step;
  always_comb begin
    if (cmd.accept) begin
      map_rd_addr = (in_data.op == OP_ALLOC) ? start_id[ID_BITS-1:BIT_IDX_BITS] :
                    in_data.target_id[ID_BITS-1:BIT_IDX_BITS];
    end else begin
      map_rd_addr = scan_idx_r + WORD_IDX_BITS'(1);
    end
  end

  rcidalloc_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_map_ram (
    .clk     (clk),
    .wr_en   (map_wr_en),
    .wr_addr (map_wr_addr),
    .wr_data (map_wr_data),
    .rd_en   (map_rd_en),
    .rd_addr (map_rd_addr),
    .rd_data (map_rdata)
  );

  rcidalloc_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_IDS)) u_cnt_ram (
    .clk     (clk),
    .wr_en   (cnt_wr_en),
    .wr_addr (cnt_wr_addr),
    .wr_data (cnt_wr_data),
    .rd_en   (cmd.accept),
    .rd_addr (in_data.target_id),
    .rd_data (cnt_rdata)
  );

  // rows never written since reset or clear read as their reset value
  assign eff_word = map_vld_q ? map_rdata : (map_row0_q ? RESERVED_WORD : '0);

  assign scan_word = eff_word |
                     ((scan_i_r == '0) ? ((WORD_BITS'(1) << start_bit_r) - WORD_BITS'(1)) : '0);
  assign found     = ~&scan_word;
  assign free_pos  = lowest_set(~scan_word);
  assign new_id    = {scan_idx_r, free_pos};

  assign tgt_active   = eff_word[id_r[BIT_IDX_BITS-1:0]];
  assign tgt_reserved = id_r < ID_BITS'(FIRST_FREE_ID);
  assign cnt_inc      = (&cnt_rdata) ? cnt_rdata : cnt_rdata + COUNT_BITS'(1);
  assign cnt_ext      = CNT_EXT_BITS'(cnt_rdata);
  assign rel_ext      = CNT_EXT_BITS'(rel_r);
  assign dec_ext      = (cnt_ext > rel_ext) ? cnt_ext - rel_ext : '0;
  assign cnt_dec      = COUNT_BITS'(dec_ext);

  assign sts.in_is_alloc = in_data.op == OP_ALLOC;
  assign sts.found       = found;
  assign sts.scan_last   = scan_i_r == SCAN_BITS'(MAP_WORDS);
  assign sts.slot_free   = !out_valid_r || out_ready;

  always_comb begin
    out_nxt     = '0;
    map_wr_en   = 1'b0;
    map_wr_addr = id_r[ID_BITS-1:BIT_IDX_BITS];
    map_wr_data = eff_word & ~(WORD_BITS'(1) << id_r[BIT_IDX_BITS-1:0]);
    cnt_wr_en   = 1'b0;
    cnt_wr_addr = id_r;
    cnt_wr_data = cnt_inc;
    do_clear    = 1'b0;
    if (cmd.scan_fire) begin
      if (found) begin
        out_nxt.result_id = new_id;
        out_nxt.is_active = 1'b1;
        out_nxt.status    = ST_DONE;
        map_wr_en         = 1'b1;
        map_wr_addr       = scan_idx_r;
        map_wr_data       = eff_word | (WORD_BITS'(1) << free_pos);
        cnt_wr_en         = 1'b1;
        cnt_wr_addr       = new_id;
        cnt_wr_data       = '0;
      end else begin
        out_nxt.status = ST_FULL;
      end
    end else if (cmd.exec_fire) begin
      unique case (op_r)
        OP_REF: begin
          if (tgt_reserved || !tgt_active) begin
            out_nxt.status = ST_IGNORED;
          end else begin
            cnt_wr_en         = 1'b1;
            cnt_wr_data       = cnt_inc;
            out_nxt.ref_count = sat_out(cnt_inc);
          end
        end
        OP_FORGET: begin
          if (tgt_reserved || !tgt_active) begin
            out_nxt.status = ST_IGNORED;
          end else begin
            cnt_wr_en         = 1'b1;
            cnt_wr_data       = cnt_dec;
            map_wr_en         = cnt_dec == '0;
            out_nxt.ref_count = sat_out(cnt_dec);
          end
        end
        OP_QUERY: begin
          out_nxt.is_active = tgt_active;
          if (tgt_active && !tgt_reserved) begin
            out_nxt.ref_count = sat_out(cnt_rdata);
          end
        end
        OP_CLEAR: begin
          do_clear = 1'b1;
        end
        default: begin
          out_nxt.status = ST_IGNORED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r   <= '0;
      last_r      <= ID_BITS'(FIRST_FREE_ID);
      out_valid_r <= 1'b0;
    end else begin
      if (do_clear) begin
        row_vld_r <= '0;
        last_r    <= ID_BITS'(FIRST_FREE_ID);
      end else if (map_wr_en) begin
        row_vld_r[map_wr_addr] <= 1'b1;
      end
      if (cmd.scan_fire && found) begin
        last_r <= new_id;
      end
      if (cmd.exec_fire || cmd.scan_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r        <= in_data.op;
      id_r        <= in_data.target_id;
      rel_r       <= in_data.release_count;
      scan_i_r    <= '0;
      scan_idx_r  <= start_id[ID_BITS-1:BIT_IDX_BITS];
      start_bit_r <= start_id[BIT_IDX_BITS-1:0];
    end else if (cmd.scan_step) begin
      scan_i_r   <= scan_i_r + SCAN_BITS'(1);
      scan_idx_r <= scan_idx_r + WORD_IDX_BITS'(1);
    end
    if (map_rd_en) begin
      map_vld_q  <= row_vld_r[map_rd_addr];
      map_row0_q <= map_rd_addr == '0;
    end
    if (cmd.exec_fire || cmd.scan_fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for refcounted_id_allocator: directed table, then random traffic.
// Uses rcidalloc_pkg types; results are checked against the directed table or an in-bench allocator model.
`timescale 1ns / 100ps

module tb_top import rcidalloc_pkg::*;;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_ITEMS = 924;
  localparam int N_DIRECTED = 26;
  localparam logic [2:0] OP_UNDEF_5 = 3'd5;
  localparam logic [2:0] OP_UNDEF_6 = 3'd6;
  localparam logic [2:0] OP_UNDEF_7 = 3'd7;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef struct {
    in_item_t  cmd;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // allocator model state
  logic [NUM_IDS-1:0]    used_map;
  bit   [COUNT_BITS-1:0] id_refs [NUM_IDS];
  logic [ID_BITS-1:0]    last_id;
  int                    live_ids [$];

  out_item_t expected_replies [$];
  out_item_t want_reply;
  int        error_total = 0;
  int        cycle_count = 0;
  int        sender_idle_pct = 0;
  int        sink_stall_pct = 0;

  dir_row_t directed_rows [N_DIRECTED] = '{
    '{'{OP_QUERY,   13'd0,    32'd0},    1'b1, '{13'd0, ST_DONE,    1'b1, 32'd0}},
    '{'{OP_QUERY,   13'd1,    ALL_ONES}, 1'b1, '{13'd0, ST_DONE,    1'b1, 32'd0}},
    '{'{OP_QUERY,   13'd8191, 32'd0},    1'b1, '{13'd0, ST_DONE,    1'b0, 32'd0}},
    '{'{OP_REF,     13'd0,    32'd0},    1'b1, '{13'd0, ST_IGNORED, 1'b0, 32'd0}},
    '{'{OP_FORGET,  13'd1,    ALL_ONES}, 1'b1, '{13'd0, ST_IGNORED, 1'b0, 32'd0}},
    '{'{OP_REF,     13'd5,    32'd7},    1'b1, '{13'd0, ST_IGNORED, 1'b0, 32'd0}},
    '{'{OP_FORGET,  13'd8191, 32'd1},    1'b1, '{13'd0, ST_IGNORED, 1'b0, 32'd0}},
    '{'{OP_ALLOC,   13'd8191, ALL_ONES}, 1'b1, '{13'd3, ST_DONE,    1'b1, 32'd0}},
    '{'{OP_ALLOC,   13'd0,    32'd0},    1'b1, '{13'd4, ST_DONE,    1'b1, 32'd0}},
    '{'{OP_REF,     13'd3,    32'd0},    1'b1, '{13'd0, ST_DONE,    1'b0, 32'd1}},
    '{'{OP_REF,     13'd3,    32'd0},    1'b0, '0},
    '{'{OP_REF,     13'd4,    ALL_ONES}, 1'b0, '0},
    '{'{OP_QUERY,   13'd3,    32'd0},    1'b0, '0},
    '{'{OP_FORGET,  13'd3,    32'd1},    1'b0, '0},
    '{'{OP_FORGET,  13'd3,    32'd0},    1'b0, '0},
    '{'{OP_QUERY,   13'd4,    32'd0},    1'b0, '0},
    '{'{OP_FORGET,  13'd4,    32'h8000_0000}, 1'b0, '0},
    '{'{OP_FORGET,  13'd3,    ALL_ONES}, 1'b0, '0},
    '{'{OP_QUERY,   13'd3,    32'd0},    1'b0, '0},
    '{'{OP_FORGET,  13'd3,    32'd0},    1'b1, '{13'd0, ST_IGNORED, 1'b0, 32'd0}},
    '{'{OP_UNDEF_5, 13'd3,    32'd0},    1'b1, '{13'd0, ST_IGNORED, 1'b0, 32'd0}},
    '{'{OP_UNDEF_6, 13'd8191, ALL_ONES}, 1'b1, '{13'd0, ST_IGNORED, 1'b0, 32'd0}},
    '{'{OP_UNDEF_7, 13'd0,    32'd0},    1'b1, '{13'd0, ST_IGNORED, 1'b0, 32'd0}},
    '{'{OP_ALLOC,   13'd0,    32'd0},    1'b0, '0},
    '{'{OP_CLEAR,   13'd8191, ALL_ONES}, 1'b1, '{13'd0, ST_DONE,    1'b0, 32'd0}},
    '{'{OP_ALLOC,   13'd0,    32'd0},    1'b1, '{13'd3, ST_DONE,    1'b1, 32'd0}}
  };

  refcounted_id_allocator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  function automatic void clear_model();
    used_map = '0;
    used_map[1:0] = 2'b11;
    last_id = ID_BITS'(FIRST_FREE_ID);
    live_ids.delete();
  endfunction

  function automatic out_item_t apply_command(in_item_t cmd);
    out_item_t             res;
    logic [ID_BITS:0]      start;
    logic [ID_BITS-1:0]    cand;
    logic [ID_BITS-1:0]    tid;
    logic [COUNT_BITS-1:0] cnt;
    res = '0;
    tid = cmd.target_id;
    case (cmd.op)
      OP_ALLOC: begin
        start = {1'b0, last_id} + 1'b1;
        if (start >= NUM_IDS || start < FIRST_FREE_ID) start = (ID_BITS + 1)'(FIRST_FREE_ID);
        res.status = ST_FULL;
        for (int k = 0; k < NUM_IDS; k++) begin
          cand = ID_BITS'(start + k);
          if (!used_map[cand]) begin
            used_map[cand] = 1'b1;
            id_refs[cand] = '0;
            last_id = cand;
            live_ids.push_back(int'(cand));
            res.result_id = cand;
            res.status = ST_DONE;
            res.is_active = 1'b1;
            break;
          end
        end
      end
      OP_REF: begin
        if (tid < FIRST_FREE_ID || !used_map[tid]) begin
          res.status = ST_IGNORED;
        end else begin
          if (id_refs[tid] != '1) id_refs[tid] = id_refs[tid] + 1'b1;
          res.ref_count = id_refs[tid];
        end
      end
      OP_FORGET: begin
        if (tid < FIRST_FREE_ID || !used_map[tid]) begin
          res.status = ST_IGNORED;
        end else begin
          cnt = id_refs[tid];
          cnt = (cnt > cmd.release_count) ? cnt - cmd.release_count : '0;
          id_refs[tid] = cnt;
          if (cnt == '0) begin
            used_map[tid] = 1'b0;
            for (int i = 0; i < live_ids.size(); i++) begin
              if (live_ids[i] == int'(tid)) begin
                live_ids.delete(i);
                break;
              end
            end
          end
          res.ref_count = cnt;
        end
      end
      OP_QUERY: begin
        if (used_map[tid]) begin
          res.is_active = 1'b1;
          res.ref_count = (tid < FIRST_FREE_ID) ? '0 : id_refs[tid];
        end
      end
      OP_CLEAR: clear_model();
      default: res.status = ST_IGNORED;
    endcase
    return res;
  endfunction

  // mostly well-formed traffic on live IDs, plus noise on arbitrary IDs
  function automatic in_item_t random_command();
    in_item_t cmd;
    int       pick;
    int       live_id;
    cmd.op = OP_ALLOC;
    cmd.target_id = ID_BITS'($urandom);
    cmd.release_count = $urandom;
    live_id = (live_ids.size() != 0) ? live_ids[$urandom_range(live_ids.size() - 1)]
                                     : int'(cmd.target_id);
    pick = $urandom_range(99);
    if (pick < 30) begin
      cmd.op = OP_ALLOC;
    end else if (pick < 55) begin
      cmd.op = OP_REF;
      cmd.target_id = ID_BITS'(live_id);
    end else if (pick < 70) begin
      cmd.op = OP_FORGET;
      cmd.target_id = ID_BITS'(live_id);
      case ($urandom_range(4))
        0: cmd.release_count = id_refs[cmd.target_id];
        1: ;
        default: cmd.release_count = $urandom_range(3, 1);
      endcase
    end else if (pick < 80) begin
      cmd.op = OP_QUERY;
      cmd.target_id = ID_BITS'(live_id);
    end else if (pick < 95) begin
      case ($urandom_range(2))
        0: cmd.op = OP_REF;
        1: cmd.op = OP_FORGET;
        default: cmd.op = OP_QUERY;
      endcase
      if (pick >= 92) cmd.target_id = ID_BITS'($urandom_range(1));
    end else if (pick < 99) begin
      case ($urandom_range(2))
        0: cmd.op = OP_UNDEF_5;
        1: cmd.op = OP_UNDEF_6;
        default: cmd.op = OP_UNDEF_7;
      endcase
    end else begin
      cmd.op = OP_CLEAR;
    end
    return cmd;
  endfunction

  task automatic issue(input in_item_t cmd, input bit typed, input out_item_t want);
    out_item_t predicted;
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (!in_ready);
    predicted = apply_command(cmd);
    expected_replies.push_back(typed ? want : predicted);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected result transfer: result_id %0d status %0d", out_data.result_id,
               out_data.status);
        error_total++;
      end else begin
        want_reply = expected_replies.pop_front();
        if (out_data.result_id !== want_reply.result_id) begin
          $error("result_id: expected %0d, got %0d", want_reply.result_id, out_data.result_id);
          error_total++;
        end
        if (out_data.status !== want_reply.status) begin
          $error("status: expected %0d, got %0d", want_reply.status, out_data.status);
          error_total++;
        end
        if (out_data.is_active !== want_reply.is_active) begin
          $error("is_active: expected %0d, got %0d", want_reply.is_active, out_data.is_active);
          error_total++;
        end
        if (out_data.ref_count !== want_reply.ref_count) begin
          $error("ref_count: expected %0h, got %0h", want_reply.ref_count, out_data.ref_count);
          error_total++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    clear_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIRECTED; r++) begin
      issue(directed_rows[r].cmd, directed_rows[r].typed, directed_rows[r].want);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_idle_pct = 82; sink_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  sink_stall_pct = 82; end
        default: begin sender_idle_pct = 28; sink_stall_pct = 28; end
      endcase
      repeat (RANDOM_ITEMS / 4) issue(random_command(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    sink_stall_pct = 0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_total == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
